// File: src/additive_note_synthesizer_unit_defines.svh
// Assertion helpers used by the controller (ansu_ctrl).
`ifndef ADDITIVE_NOTE_SYNTHESIZER_UNIT_DEFINES_SVH
`define ADDITIVE_NOTE_SYNTHESIZER_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define ANSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define ANSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ansu_pkg.sv
package ansu_pkg;

  localparam int MAX_NOTES_DEF  = 256;
  localparam int HARMONICS_DEF  = 8;
  localparam int SINE_BITS_DEF  = 10;

  localparam int RATE_MIN   = 8000;
  localparam int RATE_MAX   = 96000;
  localparam int RATE_RESET = 44100;

  localparam int DIV_NW = 50;
  localparam int DIV_DW = 32;
  localparam int ACC_W  = 56;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         note_index;
    logic [6:0]         pitch;
    logic [6:0]         volume;
    logic [15:0]        length_cs;
    logic signed [15:0] mix_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               note_active;
    logic               track_done;
    logic               clipped;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_VDIV, S_VWAIT, S_CHK, S_RD, S_SDIV, S_SWAIT, S_EMUL, S_EDIV,
    S_EWAIT, S_RDIV, S_RWAIT, S_PDIV, S_PWAIT, S_POS, S_ENV, S_VF, S_TB,
    S_HSIN, S_HMUL1, S_HMUL2, S_HACC, S_SUM, S_SILENT, S_TDONE
  } state_t;

  typedef enum logic [2:0] {
    DV_VIB, DV_START, DV_END, DV_RECIP, DV_STEP
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     take_mix;
    logic     rd_note;
    logic     note_prep;
    logic     div_go;
    div_sel_t div_sel;
    logic     cap_vib;
    logic     cap_start;
    logic     mul_end;
    logic     cap_end;
    logic     cap_recip;
    logic     zero_recip;
    logic     cap_step;
    logic     pos;
    logic     env;
    logic     vf;
    logic     tb;
    logic     sin_harm;
    logic     hmul1;
    logic     hmul2;
    logic     hacc;
    logic     emit_sum;
    logic     emit_silent;
    logic     emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic vstale;
    logic need_note;
    logic ended;
    logic silent;
    logic cnt_zero;
    logic last_h;
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] pitch_fq(input int p);
    logic [31:0] base;
    int r;
    int oct;
    r = p;
    oct = 0;
    for (int i = 0; i < 11; i++) begin
      if (r >= 12) begin
        r = r - 12;
        oct = oct + 1;
      end
    end
    case (r)
      0:       base = 32'd1071618;
      1:       base = 32'd1135340;
      2:       base = 32'd1202851;
      3:       base = 32'd1274376;
      4:       base = 32'd1350154;
      5:       base = 32'd1430439;
      6:       base = 32'd1515497;
      7:       base = 32'd1605613;
      8:       base = 32'd1701088;
      9:       base = 32'd1802240;
      10:      base = 32'd1909407;
      default: base = 32'd2022946;
    endcase
    return base << oct;
  endfunction

  function automatic logic [15:0] note_amp(input int v);
    return 16'((v * 32767) / 200);
  endfunction

  function automatic logic [15:0] harm_weight(input int h);
    logic [15:0] w;
    case (h)
      0:       w = 16'd16384;
      1:       w = 16'd27853;
      2:       w = 16'd34406;
      3:       w = 16'd27853;
      4:       w = 16'd13107;
      5:       w = 16'd9830;
      6:       w = 16'd3277;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] harm_offset(input int h);
    logic [31:0] o;
    case (h)
      0:       o = 32'd4044427537;
      1:       o = 32'd107374182;
      2:       o = 32'd214748365;
      3:       o = 32'd35791394;
      4:       o = 32'd4187593114;
      5:       o = 32'd4211454043;
      6:       o = 32'd4271106367;
      default: o = 32'd0;
    endcase
    return o;
  endfunction

  function automatic logic [15:0] quarter_sine(input int r, input int qb);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned inner;
    longint unsigned inner2;
    longint unsigned s;
    longint unsigned v;
    t = (64'(r) << 16) >> qb;
    t2 = (t * t) >> 16;
    inner = 64'd42334 - ((t2 * 64'd4926) >> 16);
    inner2 = 64'd102944 - ((t2 * inner) >> 16);
    s = (t * inner2) >> 16;
    v = (s * 64'd32767 + 64'd32768) >> 16;
    if (v > 64'd32767) v = 64'd32767;
    return 16'(v);
  endfunction

endpackage

// File: src/additive_note_synthesizer_unit.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data (in_item_t)
// out      output     out_valid / out_ready  out_data (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample item with the note already running steps the shared multiply path one harmonic
// at a time. Starting a note adds two passes of the serial divider and two divisions by
// 100 (one serial pass for a note of zero samples); a sample after a sample_rate write
// adds one more serial divider pass.
// Reset is synchronous and clears all playback state; the note table holds no reset value.
// A new item is taken while the previous result still waits in the output register.
module additive_note_synthesizer_unit #(
  parameter int MAX_NOTES       = ansu_pkg::MAX_NOTES_DEF,
  parameter int HARMONICS       = ansu_pkg::HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = ansu_pkg::SINE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ansu_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ansu_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ansu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ansu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ansu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ansu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ansu_dp #(
    .MAX_NOTES       (MAX_NOTES),
    .HARMONICS       (HARMONICS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// File: src/ansu_div.sv
module ansu_div #(
  parameter int NW = ansu_pkg::DIV_NW,
  parameter int DW = ansu_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvsr_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   shift;
  logic [DW+1:0] diff;

  assign shift = {rem_r, quo_r[NW-1]};
  assign diff  = {1'b0, shift} - {2'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DW+1]) begin
        rem_r <= diff[DW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= shift[DW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// File: src/ansu_dp.sv
module ansu_dp #(
  parameter int MAX_NOTES       = ansu_pkg::MAX_NOTES_DEF,
  parameter int HARMONICS       = ansu_pkg::HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = ansu_pkg::SINE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ansu_pkg::dp_cmd_t                  cmd,
  output ansu_pkg::dp_sts_t                  sts,
  input  ansu_pkg::in_item_t                 in_data,
  input  logic                               cfg_valid,
  input  logic [ansu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ansu_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ansu_pkg::out_item_t                out_data
);
  import ansu_pkg::*;

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int PW = $clog2(MAX_NOTES + 1);
  localparam int HW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int SB = SINE_TABLE_BITS;
  localparam int QB = SB - 2;
  localparam int QN = 1 << QB;
  localparam int RW = ACC_W - 30;
  localparam logic [31:0] C100_MUL = 32'd1374389535;

  logic [8:0]            ncount_r;
  logic [16:0]           rate_r;
  logic                  vstale_r;
  logic [PW-1:0]         ptr_r;
  logic [31:0]           elapsed_r;
  logic [31:0]           idx_r;
  logic [31:0]           cnt_r;
  logic [31:0]           recip_r;
  logic [31:0]           base_r;
  logic [31:0]           step_r;
  logic [31:0]           vib_r;
  logic [31:0]           vstep_r;
  logic [15:0]           amp_r;
  logic [31:0]           start_r;
  logic signed [15:0]    mix_r;
  logic [31:0]           mul_r;
  logic [16:0]           pos_r;
  logic [15:0]           env_r;
  logic [13:0]           depth_r;
  logic [16:0]           vf_r;
  logic [16:0]           tb_r;
  logic signed [15:0]    sin_r;
  logic signed [33:0]    p1_r;
  logic signed [50:0]    p2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [31:0]           hp_r;
  logic [HW-1:0]         h_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic [1:0]            c_st_r;
  logic                  c_busy_r;
  logic                  c_done_r;
  logic [25:0]           c_q_r;
  logic [6:0]            c_rem_r;
  logic [31:0]           c_hi_r;
  logic [23:0]           c_lo_r;
  logic [31:0]           c_res_r;

  logic [29:0]           mem [MAX_NOTES];
  logic [29:0]           mem_q;

  logic [31:0]           fq_tab [128];
  logic [15:0]           amp_tab [128];
  logic [15:0]           qs_tab [QN+1];

  logic [16:0]           rate_now;
  logic [PW-1:0]         limit;
  logic [63:0]           pos_full;
  logic [32:0]           env_full;
  logic [30:0]           dep_full;
  logic signed [30:0]    dv;
  logic signed [30:0]    dv_rnd;
  logic signed [15:0]    dvq;
  logic [32:0]           tb_full;
  logic [31:0]           ph;
  logic [SB-1:0]         sin_addr;
  logic [QB:0]           qidx;
  logic [15:0]           qval;
  logic [DIV_NW-1:0]     div_dividend;
  logic [DIV_DW-1:0]     div_divisor;
  logic [DIV_NW-1:0]     div_q;
  logic [DIV_NW-1:0]     div_sq;
  logic                  div_busy;
  logic                  div_done;
  logic                  c_go;
  logic                  s_go;
  logic [63:0]           c_qfull;
  logic [31:0]           c_qx100;
  logic [31:0]           c_rfull;
  logic [42:0]           c_hfull;
  logic [63:0]           c_lfull;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RW-1:0]  res_w;
  logic signed [15:0]    res_sat;
  logic                  res_clip;
  logic                  slot_ok;

  for (genvar g = 0; g < 128; g++) begin : g_tabs
    assign fq_tab[g]  = pitch_fq(g);
    assign amp_tab[g] = note_amp(g);
  end

  for (genvar g = 0; g <= QN; g++) begin : g_qs
    assign qs_tab[g] = quarter_sine(g, QB);
  end

  always_comb begin
    if (rate_r < 17'(RATE_MIN)) begin
      rate_now = 17'(RATE_MIN);
    end else if (rate_r > 17'(RATE_MAX)) begin
      rate_now = 17'(RATE_MAX);
    end else begin
      rate_now = rate_r;
    end
    if (32'(ncount_r) > 32'(MAX_NOTES)) begin
      limit = PW'(MAX_NOTES);
    end else begin
      limit = PW'(ncount_r);
    end
  end

  assign slot_ok  = 32'(in_data.note_index) < 32'(MAX_NOTES);
  assign pos_full = idx_r * recip_r;
  assign env_full = amp_r * (17'h10000 - pos_r);
  assign dep_full = pos_r * 14'd13107;
  assign dv       = $signed({1'b0, depth_r}) * sin_r;
  assign dv_rnd   = dv + (dv[30] ? 31'sd32767 : 31'sd0);
  assign dvq      = dv_rnd[30:15];
  assign tb_full  = env_r * vf_r;
  assign ph       = hp_r + harm_offset(int'(h_r));

  always_comb begin
    sin_addr = cmd.pos ? vib_r[31 -: SB] : ph[31 -: SB];
    if (sin_addr[SB-2]) begin
      qidx = (QB+1)'(QN) - {1'b0, sin_addr[QB-1:0]};
    end else begin
      qidx = {1'b0, sin_addr[QB-1:0]};
    end
    qval = qs_tab[qidx];
  end

  always_comb begin
    div_dividend = '0;
    div_divisor  = 32'd100;
    case (cmd.div_sel)
      DV_VIB: begin
        div_dividend = DIV_NW'(64'd1 << 35);
        div_divisor  = 32'(rate_now);
      end
      DV_RECIP: begin
        div_dividend = DIV_NW'(32'hFFFF_FFFF);
        div_divisor  = cnt_r;
      end
      DV_STEP: begin
        div_dividend = DIV_NW'({fq_tab[mem_q[29:23]], 16'h0000});
        div_divisor  = 32'(rate_now);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = 32'd100;
      end
    endcase
  end

  assign c_go = cmd.div_go && (cmd.div_sel == DV_START || cmd.div_sel == DV_END);
  assign s_go = cmd.div_go && !c_go;

  ansu_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_sq)
  );

  // Sample position elapsed * rate / 100, split as elapsed = 100 * q + r.
  assign c_qfull = mul_r * C100_MUL;
  assign c_qx100 = c_q_r * 32'd100;
  assign c_rfull = mul_r - c_qx100;
  assign c_hfull = c_q_r * rate_now;
  assign c_lfull = c_lo_r * C100_MUL;
  assign div_q   = c_done_r ? {{(DIV_NW-32){1'b0}}, c_res_r} : div_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_busy_r <= 1'b0;
      c_done_r <= 1'b0;
      c_st_r   <= '0;
    end else begin
      c_done_r <= 1'b0;
      if (c_go) begin
        c_busy_r <= 1'b1;
        c_st_r   <= 2'd1;
      end else if (c_busy_r) begin
        c_st_r <= c_st_r + 1'b1;
        if (c_st_r == 2'd3) begin
          c_busy_r <= 1'b0;
          c_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      c_q_r <= c_qfull[62:37];
    end
    if (c_busy_r && c_st_r == 2'd1) begin
      c_rem_r <= c_rfull[6:0];
      c_hi_r  <= c_hfull[31:0];
    end
    if (c_busy_r && c_st_r == 2'd2) begin
      c_lo_r <= c_rem_r * rate_now;
    end
    if (c_busy_r && c_st_r == 2'd3) begin
      c_res_r <= c_hi_r + {5'b0, c_lfull[63:37]};
    end
  end

  always_comb begin
    acc_rnd  = acc_r + (acc_r[ACC_W-1] ? ACC_W'(64'd1073741823) : ACC_W'(0));
    res_w    = acc_rnd[ACC_W-1:30];
    res_clip = 1'b0;
    if (res_w > RW'(32767)) begin
      res_sat  = 16'sh7FFF;
      res_clip = 1'b1;
    end else if (res_w < -RW'(32768)) begin
      res_sat  = -16'sh8000;
      res_clip = 1'b1;
    end else begin
      res_sat = res_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      mem[AW'(in_data.note_index)] <= {in_data.pitch, in_data.volume, in_data.length_cs};
    end
    if (cmd.rd_note) begin
      mem_q <= mem[ptr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r  <= '0;
      rate_r    <= 17'(RATE_RESET);
      vstale_r  <= 1'b1;
      ptr_r     <= '0;
      elapsed_r <= '0;
      idx_r     <= '0;
      cnt_r     <= '0;
      recip_r   <= '0;
      base_r    <= '0;
      step_r    <= '0;
      vib_r     <= '0;
      amp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_NOTE_COUNT:  ncount_r <= cfg_data[8:0];
          REG_SAMPLE_RATE: begin
            rate_r   <= cfg_data;
            vstale_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.cap_vib) begin
        vstale_r <= 1'b0;
      end
      if (cmd.load) begin
        ptr_r     <= '0;
        elapsed_r <= '0;
        idx_r     <= '0;
        cnt_r     <= '0;
        recip_r   <= '0;
        base_r    <= '0;
        step_r    <= '0;
        vib_r     <= '0;
        amp_r     <= '0;
      end
      if (cmd.note_prep) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.cap_start) begin
        elapsed_r <= elapsed_r + 32'(mem_q[15:0]);
      end
      if (cmd.cap_end) begin
        cnt_r  <= div_q[31:0] - start_r;
        idx_r  <= '0;
        base_r <= '0;
        vib_r  <= '0;
        amp_r  <= amp_tab[mem_q[22:16]];
      end
      if (cmd.cap_recip) begin
        recip_r <= div_q[31:0];
      end
      if (cmd.zero_recip) begin
        recip_r <= '0;
      end
      if (cmd.cap_step) begin
        step_r <= div_q[31:0];
      end
      if (cmd.emit_sum || cmd.emit_silent) begin
        base_r <= base_r + step_r;
        vib_r  <= vib_r + vstep_r;
        idx_r  <= idx_r + 1'b1;
      end
      if (cmd.emit_sum || cmd.emit_silent || cmd.emit_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_mix) begin
      mix_r <= in_data.mix_in;
    end
    if (cmd.cap_vib) begin
      vstep_r <= div_q[31:0];
    end
    if (cmd.note_prep || cmd.mul_end) begin
      mul_r <= elapsed_r;
    end
    if (cmd.cap_start) begin
      start_r <= div_q[31:0];
    end
    if (cmd.pos) begin
      pos_r <= pos_full[32:16];
      hp_r  <= base_r;
      h_r   <= '0;
    end
    if (cmd.pos || cmd.sin_harm) begin
      sin_r <= sin_addr[SB-1] ? -$signed(qval) : $signed(qval);
    end
    if (cmd.env) begin
      env_r   <= env_full[31:16];
      depth_r <= dep_full[29:16];
    end
    if (cmd.vf) begin
      vf_r <= 17'(18'sd65536 + 18'(dvq));
    end
    if (cmd.tb) begin
      tb_r  <= tb_full[32:16];
      acc_r <= ACC_W'(mix_r) <<< 30;
    end
    if (cmd.hmul1) begin
      p1_r <= $signed({1'b0, tb_r}) * sin_r;
    end
    if (cmd.hmul2) begin
      p2_r <= p1_r * $signed({1'b0, harm_weight(int'(h_r))});
    end
    if (cmd.hacc) begin
      acc_r <= acc_r + ACC_W'(p2_r);
      hp_r  <= hp_r + base_r;
      h_r   <= h_r + 1'b1;
    end
    if (cmd.emit_sum) begin
      out_data_r.sample_out  <= res_sat;
      out_data_r.note_active <= 1'b1;
      out_data_r.track_done  <= 1'b0;
      out_data_r.clipped     <= res_clip;
    end else if (cmd.emit_silent || cmd.emit_done) begin
      out_data_r.sample_out  <= mix_r;
      out_data_r.note_active <= 1'b0;
      out_data_r.track_done  <= cmd.emit_done;
      out_data_r.clipped     <= 1'b0;
    end
  end

  always_comb begin
    sts.div_busy  = div_busy || c_busy_r;
    sts.div_done  = div_done || c_done_r;
    sts.vstale    = vstale_r;
    sts.ended     = idx_r >= cnt_r;
    sts.need_note = (idx_r >= cnt_r) && (ptr_r < limit);
    sts.silent    = amp_r == '0;
    sts.cnt_zero  = cnt_r == '0;
    sts.last_h    = h_r == HW'(HARMONICS - 1);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

// File: src/ansu_ctrl.sv
`include "additive_note_synthesizer_unit_defines.svh"

module ansu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req,
  output logic              in_ready,
  output ansu_pkg::dp_cmd_t cmd,
  input  ansu_pkg::dp_sts_t sts
);
  import ansu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_req) state_nxt = sts.vstale ? S_VDIV : S_CHK;
      end
      S_VDIV:  state_nxt = S_VWAIT;
      S_VWAIT: if (sts.div_done) state_nxt = S_CHK;
      S_CHK: begin
        if (sts.need_note)   state_nxt = S_RD;
        else if (sts.ended)  state_nxt = S_TDONE;
        else if (sts.silent) state_nxt = S_SILENT;
        else                 state_nxt = S_POS;
      end
      S_RD:    state_nxt = S_SDIV;
      S_SDIV:  state_nxt = S_SWAIT;
      S_SWAIT: if (sts.div_done) state_nxt = S_EMUL;
      S_EMUL:  state_nxt = S_EDIV;
      S_EDIV:  state_nxt = S_EWAIT;
      S_EWAIT: if (sts.div_done) state_nxt = S_RDIV;
      S_RDIV:  state_nxt = sts.cnt_zero ? S_PDIV : S_RWAIT;
      S_RWAIT: if (sts.div_done) state_nxt = S_PDIV;
      S_PDIV:  state_nxt = S_PWAIT;
      S_PWAIT: if (sts.div_done) state_nxt = S_CHK;
      S_POS:   state_nxt = S_ENV;
      S_ENV:   state_nxt = S_VF;
      S_VF:    state_nxt = S_TB;
      S_TB:    state_nxt = S_HSIN;
      S_HSIN:  state_nxt = S_HMUL1;
      S_HMUL1: state_nxt = S_HMUL2;
      S_HMUL2: state_nxt = S_HACC;
      S_HACC:  state_nxt = sts.last_h ? S_SUM : S_HSIN;
      S_SUM, S_SILENT, S_TDONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load     = in_valid && !in_req;
        cmd.take_mix = in_valid && in_req;
      end
      S_VDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DV_VIB;
      end
      S_VWAIT: cmd.cap_vib = sts.div_done;
      S_CHK:   cmd.rd_note = sts.need_note;
      S_RD:    cmd.note_prep = 1'b1;
      S_SDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DV_START;
      end
      S_SWAIT: cmd.cap_start = sts.div_done;
      S_EMUL:  cmd.mul_end = 1'b1;
      S_EDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DV_END;
      end
      S_EWAIT: cmd.cap_end = sts.div_done;
      S_RDIV: begin
        cmd.zero_recip = sts.cnt_zero;
        cmd.div_go     = !sts.cnt_zero;
        cmd.div_sel    = DV_RECIP;
      end
      S_RWAIT: cmd.cap_recip = sts.div_done;
      S_PDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DV_STEP;
      end
      S_PWAIT:  cmd.cap_step = sts.div_done;
      S_POS:    cmd.pos = 1'b1;
      S_ENV:    cmd.env = 1'b1;
      S_VF:     cmd.vf = 1'b1;
      S_TB:     cmd.tb = 1'b1;
      S_HSIN:   cmd.sin_harm = 1'b1;
      S_HMUL1:  cmd.hmul1 = 1'b1;
      S_HMUL2:  cmd.hmul2 = 1'b1;
      S_HACC:   cmd.hacc = 1'b1;
      S_SUM:    cmd.emit_sum = sts.out_free;
      S_SILENT: cmd.emit_silent = sts.out_free;
      S_TDONE:  cmd.emit_done = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  `ANSU_ASSERT(a_div_idle, cmd.div_go |-> !sts.div_busy, "Divider started while busy.")
  `ANSU_ASSERT(a_emit_free, (cmd.emit_sum || cmd.emit_silent || cmd.emit_done) |-> sts.out_free, "Result written over a pending item.")
  `ANSU_ASSERT(a_one_item, (in_valid && in_ready && in_req) |=> !in_ready, "Second item taken during a sample.")
  `ANSU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE), "Controller not idle after reset.")
endmodule
